### sv/rcap_pkg.sv
package rcap_pkg;

  // register map: one 32-bit word per register
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic REG_LENGTH_LIMIT = 1'b0;
  localparam logic REG_COUNT_LIMIT  = 1'b1;

  localparam logic [10:0] LENGTH_LIMIT_RST = 11'd100;
  localparam logic [15:0] COUNT_LIMIT_RST  = 16'd64;
  localparam logic [10:0] LEN_CAP          = 11'd1024;

  localparam logic [16:0] NUM_SAT = 17'h1FFFF;

  // characters of interest
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_ARG_DONE  = 2'd1,
    KIND_EMPTY_REQ = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_ARR_MARKER = 3'd1,
    ERR_BULK_MARKER = 3'd2,
    ERR_BAD_LENGTH = 3'd3,
    ERR_COUNT_OVER = 3'd4,
    ERR_LINE_LONG  = 3'd5
  } err_t;

  typedef struct packed {
    logic [10:0] length_limit;
    logic [15:0] count_limit;
  } rcap_cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] arg_index;
    logic [9:0]  arg_length;
    logic        last_arg;
    logic [15:0] arg_count;
    err_t        error_code;
  } rcap_result_t;

endpackage

### sv/rcap_if.sv
interface rcap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface rcap_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] arg_index;
  logic [9:0]  arg_length;
  logic        last_arg;
  logic [15:0] arg_count;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output data_byte, output arg_index,
                  output arg_length, output last_arg, output arg_count,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input data_byte, input arg_index,
                  input arg_length, input last_arg, input arg_count,
                  input error_code, output ready);
endinterface

### sv/rcap_cfg.sv
module rcap_cfg import rcap_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output rcap_cfg_t         cfg
);

  logic [10:0] length_limit;
  logic [15:0] count_limit;
  logic        reg_sel;
  logic        wr_en;

  assign reg_sel = paddr[ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LENGTH_LIMIT_RST;
      count_limit  <= COUNT_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LENGTH_LIMIT: length_limit <= pwdata[10:0];
        REG_COUNT_LIMIT:  count_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LENGTH_LIMIT: prdata = {21'b0, length_limit};
      REG_COUNT_LIMIT:  prdata = {16'b0, count_limit};
      default:          prdata = '0;
    endcase
  end

  assign cfg.length_limit = length_limit;
  assign cfg.count_limit  = count_limit;

endmodule

### sv/rcap_core.sv
module rcap_core import rcap_pkg::*; #(
  parameter int unsigned MAX_LINE = 200
) (
  input  logic         clk,
  input  logic         rst,
  rcap_in_if.sink      req,
  input  rcap_cfg_t    cfg,
  input  logic         space,
  output logic         res_valid,
  output rcap_result_t res
);

  localparam int unsigned LW = $clog2(MAX_LINE);

  typedef enum logic [2:0] {
    PH_ARR      = 3'd0,
    PH_ARR_BAD  = 3'd1,
    PH_BULK     = 3'd2,
    PH_BULK_BAD = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_TRAILER  = 3'd5
  } phase_t;

  // input register
  logic       in_v;
  logic [7:0] b;
  logic       proc;

  phase_t      phase, phase_next;
  logic [LW-1:0] line_position, line_position_next;
  logic        prev_was_cr, prev_was_cr_next;
  logic        number_negative, number_negative_next;
  logic        number_stopped, number_stopped_next;
  logic        number_started, number_started_next;
  logic [16:0] number_value, number_value_next;
  logic [15:0] args_total, args_total_next;
  logic [15:0] args_done, args_done_next;
  logic [9:0]  bytes_left, bytes_left_next;
  logic [1:0]  trailer_left, trailer_left_next;

  logic        do_resync;
  logic [LW:0] lp_inc;
  logic        line_end_hit;
  logic [10:0] lim;
  logic        nonpos;
  logic        last;
  logic        digit;
  logic        ws;
  logic        sgn;
  logic [20:0] prod;

  assign proc      = in_v && space;
  assign req.ready = !in_v || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_v <= 1'b1;
    end else if (proc) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      b <= req.in_byte;
    end
  end

  always_comb begin
    phase_next           = phase;
    line_position_next   = line_position;
    prev_was_cr_next     = prev_was_cr;
    number_negative_next = number_negative;
    number_stopped_next  = number_stopped;
    number_started_next  = number_started;
    number_value_next    = number_value;
    args_total_next      = args_total;
    args_done_next       = args_done;
    bytes_left_next      = bytes_left;
    trailer_left_next    = trailer_left;
    res_valid            = 1'b0;
    res                  = '0;
    do_resync            = 1'b0;

    lp_inc       = {1'b0, line_position} + {{LW{1'b0}}, 1'b1};
    line_end_hit = (line_position != '0) && prev_was_cr && (b == CH_LF);
    lim          = (cfg.length_limit > LEN_CAP) ? LEN_CAP : cfg.length_limit;
    nonpos       = number_negative || (number_value == '0);
    last         = ({1'b0, args_done} + 17'd1) >= {1'b0, args_total};
    digit        = (b >= CH_ZERO) && (b <= CH_NINE);
    ws           = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    sgn          = (b == CH_PLUS) || (b == CH_MINUS);
    prod         = ({4'b0, number_value} << 3) + ({4'b0, number_value} << 1)
                   + {17'b0, b[3:0]};

    if (proc) begin
      unique case (phase)
        PH_PAYLOAD: begin
          res_valid      = 1'b1;
          res.kind       = KIND_PAYLOAD;
          res.data_byte  = b;
          res.arg_index  = args_done;
          res.arg_length = number_value[9:0];
          res.arg_count  = args_total;
          if (bytes_left <= 10'd1) begin
            bytes_left_next   = '0;
            phase_next        = PH_TRAILER;
            trailer_left_next = 2'd2;
          end else begin
            bytes_left_next = bytes_left - 10'd1;
          end
        end
        PH_TRAILER: begin
          if (trailer_left > 2'd1) begin
            trailer_left_next = trailer_left - 2'd1;
          end else begin
            res_valid         = 1'b1;
            res.kind          = KIND_ARG_DONE;
            res.arg_index     = args_done;
            res.arg_length    = number_value[9:0];
            res.last_arg      = last;
            res.arg_count     = args_total;
            trailer_left_next = '0;
            if (last) begin
              do_resync = 1'b1;
            end else begin
              args_done_next       = args_done + 16'd1;
              phase_next           = PH_BULK;
              number_value_next    = '0;
              line_position_next   = '0;
              prev_was_cr_next     = 1'b0;
              number_negative_next = 1'b0;
              number_stopped_next  = 1'b0;
              number_started_next  = 1'b0;
            end
          end
        end
        PH_ARR, PH_ARR_BAD, PH_BULK, PH_BULK_BAD: begin
          if (line_end_hit) begin
            res.arg_index = args_done;
            res.arg_count = args_total;
            if (phase == PH_ARR_BAD) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_ARR_MARKER;
              do_resync      = 1'b1;
            end else if (phase == PH_BULK_BAD) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BULK_MARKER;
              do_resync      = 1'b1;
            end else if (phase == PH_ARR) begin
              if (nonpos) begin
                res_valid = 1'b1;
                res       = '0;
                res.kind  = KIND_EMPTY_REQ;
                do_resync = 1'b1;
              end else if (number_value > {1'b0, cfg.count_limit}) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_COUNT_OVER;
                do_resync      = 1'b1;
              end else begin
                args_total_next      = number_value[15:0];
                args_done_next       = '0;
                phase_next           = PH_BULK;
                number_value_next    = '0;
                line_position_next   = '0;
                prev_was_cr_next     = 1'b0;
                number_negative_next = 1'b0;
                number_stopped_next  = 1'b0;
                number_started_next  = 1'b0;
              end
            end else begin
              if ((number_negative && (number_value != '0))
                  || (number_value >= {6'b0, lim})) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_BAD_LENGTH;
                do_resync      = 1'b1;
              end else begin
                line_position_next   = '0;
                prev_was_cr_next     = 1'b0;
                number_negative_next = 1'b0;
                number_stopped_next  = 1'b0;
                number_started_next  = 1'b0;
                bytes_left_next      = number_value[9:0];
                if (number_value == '0) begin
                  phase_next        = PH_TRAILER;
                  trailer_left_next = 2'd2;
                end else begin
                  phase_next = PH_PAYLOAD;
                end
              end
            end
          end else begin
            if (line_position == '0) begin
              // marker byte opens a line
              number_value_next    = '0;
              number_negative_next = 1'b0;
              number_stopped_next  = 1'b0;
              number_started_next  = 1'b0;
              if (phase == PH_ARR || phase == PH_ARR_BAD) begin
                phase_next = (b == CH_STAR) ? PH_ARR : PH_ARR_BAD;
              end else begin
                phase_next = (b == CH_DOLLAR) ? PH_BULK : PH_BULK_BAD;
              end
            end else if (!number_stopped) begin
              // atoi-style number: whitespace, sign, then digits
              if (number_started || !(ws || sgn)) begin
                number_started_next = 1'b1;
                if (digit) begin
                  number_value_next = (prod > {4'b0, NUM_SAT}) ? NUM_SAT : prod[16:0];
                end else begin
                  number_stopped_next = 1'b1;
                end
              end else if (sgn) begin
                number_started_next  = 1'b1;
                number_negative_next = (b == CH_MINUS);
              end
            end
            prev_was_cr_next   = (b == CH_CR);
            line_position_next = lp_inc[LW-1:0];
            if (lp_inc >= (LW+1)'(MAX_LINE - 1)) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.arg_index  = args_done;
              res.arg_count  = args_total;
              res.error_code = ERR_LINE_LONG;
              do_resync      = 1'b1;
            end
          end
        end
        default: do_resync = 1'b1;
      endcase
    end

    if (do_resync) begin
      phase_next           = PH_ARR;
      args_total_next      = '0;
      args_done_next       = '0;
      bytes_left_next      = '0;
      trailer_left_next    = '0;
      number_value_next    = '0;
      line_position_next   = '0;
      prev_was_cr_next     = 1'b0;
      number_negative_next = 1'b0;
      number_stopped_next  = 1'b0;
      number_started_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_ARR;
      line_position   <= '0;
      prev_was_cr     <= 1'b0;
      number_negative <= 1'b0;
      number_stopped  <= 1'b0;
      number_started  <= 1'b0;
      number_value    <= '0;
      args_total      <= '0;
      args_done       <= '0;
      bytes_left      <= '0;
      trailer_left    <= '0;
    end else if (proc) begin
      phase           <= phase_next;
      line_position   <= line_position_next;
      prev_was_cr     <= prev_was_cr_next;
      number_negative <= number_negative_next;
      number_stopped  <= number_stopped_next;
      number_started  <= number_started_next;
      number_value    <= number_value_next;
      args_total      <= args_total_next;
      args_done       <= args_done_next;
      bytes_left      <= bytes_left_next;
      trailer_left    <= trailer_left_next;
    end
  end

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != '0))
    else $error("payload phase with no bytes left");

  a_trailer_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TRAILER) |-> (trailer_left != '0))
    else $error("trailer phase with no trailer bytes left");

  a_arg_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD || phase == PH_TRAILER || phase == PH_BULK)
      |-> (args_done < args_total))
    else $error("argument index beyond declared count");

  a_error_resyncs: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_ERROR)
      |=> (phase == PH_ARR && line_position == '0 && args_total == '0))
    else $error("error not followed by resync");

endmodule

### sv/rcap_outq.sv
module rcap_outq import rcap_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  rcap_result_t push_data,
  output logic         space,
  rcap_out_if.source   rsp
);

  rcap_result_t slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         pop;
  rcap_result_t head;

  assign pop   = rsp.valid && rsp.ready;
  assign space = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  assign head           = slot[rd_ptr];
  assign rsp.valid      = (count != '0);
  assign rsp.kind       = head.kind;
  assign rsp.data_byte  = head.data_byte;
  assign rsp.arg_index  = head.arg_index;
  assign rsp.arg_length = head.arg_length;
  assign rsp.last_arg   = head.last_arg;
  assign rsp.arg_count  = head.arg_count;
  assign rsp.error_code = head.error_code;

endmodule

### sv/resp_command_array_parser.sv
// a byte taken on the request channel passes the input register, then the
// combinational parse step into a slot of the output queue
// throughput: one byte per cycle while the output queue has room; the two-entry
// output queue parts the input and output handshakes
// reset: synchronous rst clears all parser state and the queue; the limits
// return to 100 (length) and 64 (count)
module resp_command_array_parser import rcap_pkg::*; #(
  parameter int unsigned MAX_LINE = 200
) (
  input  logic              clk,
  input  logic              rst,
  rcap_in_if.sink           req,
  rcap_out_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // limits seen by the parser
  rcap_cfg_t    cfg;

  // parser to output queue
  logic         space;
  logic         res_valid;
  rcap_result_t res;

  // register block, APB-style writes and reads
  rcap_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // captures one byte a cycle while the output queue has room and runs the header/payload/trailer parse
  rcap_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .space     (space),
    .res_valid (res_valid),
    .res       (res)
  );

  // two-entry skid queue holding results until the sink takes the transaction
  rcap_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .rsp       (rsp)
  );

endmodule

### sim/tb_resp_command_array_parser.sv
module tb_resp_command_array_parser;
  import rcap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX     = 200;
  localparam int unsigned SETTLE_TICKS = 6;       // output pipe depth plus margin
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // parsing states of the predictor: header lines, payload and trailer
  typedef enum logic [2:0] {
    P_COUNT_LINE,
    P_COUNT_BAD,
    P_LEN_LINE,
    P_LEN_BAD,
    P_PAYLOAD,
    P_TRAILER
  } parse_phase_t;

  logic clk;
  logic rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rcap_in_if  req_if ();
  rcap_out_if rsp_if ();

  resp_command_array_parser #(
    .MAX_LINE (LINE_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if.sink),
    .rsp     (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 8 ns period, inputs move on the falling edge
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // predictor copy of the limits and the parser state
  int unsigned  length_lim;
  int unsigned  count_lim;
  parse_phase_t parse_phase;
  int unsigned  line_pos;
  bit           prev_cr;
  bit           num_neg;
  bit           num_stopped;
  bit           num_started;
  int unsigned  num_value;
  int unsigned  args_total;
  int unsigned  args_done;
  int unsigned  bytes_left;
  int unsigned  trailer_left;

  rcap_result_t pending_parse_results[$];
  int unsigned  fail_count;
  int unsigned  bytes_accepted;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;

  function automatic void expect_result(kind_t k, logic [7:0] data, logic [15:0] idx,
                                        logic [9:0] len, logic last, logic [15:0] cnt,
                                        err_t code);
    rcap_result_t r;
    r.kind       = k;
    r.data_byte  = data;
    r.arg_index  = idx;
    r.arg_length = len;
    r.last_arg   = last;
    r.arg_count  = cnt;
    r.error_code = code;
    pending_parse_results.push_back(r);
  endfunction

  function automatic void clear_line_state();
    line_pos    = 0;
    prev_cr     = 1'b0;
    num_neg     = 1'b0;
    num_stopped = 1'b0;
    num_started = 1'b0;
  endfunction

  // back to waiting for the count line of a new request
  function automatic void restart_request();
    parse_phase  = P_COUNT_LINE;
    args_total   = 0;
    args_done    = 0;
    bytes_left   = 0;
    trailer_left = 0;
    num_value    = 0;
    clear_line_state();
  endfunction

  function automatic void flag_error(err_t code);
    expect_result(KIND_ERROR, 8'h00, 16'(args_done), 10'd0, 1'b0, 16'(args_total), code);
    restart_request();
  endfunction

  // one accepted request byte through the parser
  function automatic void parse_byte(logic [7:0] b);
    bit          last;
    bit          blank;
    int unsigned len_cap;
    int unsigned v;
    case (parse_phase)
      P_PAYLOAD: begin
        expect_result(KIND_PAYLOAD, b, 16'(args_done), 10'(num_value), 1'b0,
                      16'(args_total), ERR_NONE);
        if (bytes_left <= 1) begin
          bytes_left   = 0;
          parse_phase  = P_TRAILER;
          trailer_left = 2;
        end else begin
          bytes_left--;
        end
      end
      P_TRAILER: begin
        // trailer content is never looked at, only the second byte reports
        if (trailer_left > 1) begin
          trailer_left--;
        end else begin
          last = (args_done + 1 >= args_total);
          expect_result(KIND_ARG_DONE, 8'h00, 16'(args_done), 10'(num_value), last,
                        16'(args_total), ERR_NONE);
          trailer_left = 0;
          if (last) begin
            restart_request();
          end else begin
            args_done   = (args_done + 1) & 16'hFFFF;
            parse_phase = P_LEN_LINE;
            num_value   = 0;
            clear_line_state();
          end
        end
      end
      default: begin
        if (line_pos != 0 && prev_cr && b == CH_LF) begin
          // header line complete
          v = num_value;
          case (parse_phase)
            P_COUNT_BAD: flag_error(ERR_ARR_MARKER);
            P_LEN_BAD:   flag_error(ERR_BULK_MARKER);
            P_COUNT_LINE: begin
              if (num_neg || v == 0) begin
                expect_result(KIND_EMPTY_REQ, 8'h00, 16'd0, 10'd0, 1'b0, 16'd0, ERR_NONE);
                restart_request();
              end else if (v > count_lim) begin
                flag_error(ERR_COUNT_OVER);
              end else begin
                args_total  = v;
                args_done   = 0;
                parse_phase = P_LEN_LINE;
                clear_line_state();
                num_value   = 0;
              end
            end
            default: begin
              len_cap = (length_lim > LEN_CAP) ? LEN_CAP : length_lim;
              if ((num_neg && v != 0) || v >= len_cap) begin
                flag_error(ERR_BAD_LENGTH);
              end else begin
                clear_line_state();
                num_value  = v;
                bytes_left = v;
                if (v == 0) begin
                  parse_phase  = P_TRAILER;
                  trailer_left = 2;
                end else begin
                  parse_phase = P_PAYLOAD;
                end
              end
            end
          endcase
        end else begin
          if (line_pos == 0) begin
            // marker byte, a wrong one only shows when the line ends
            clear_line_state();
            num_value = 0;
            if (parse_phase == P_COUNT_LINE || parse_phase == P_COUNT_BAD) begin
              parse_phase = (b == CH_STAR) ? P_COUNT_LINE : P_COUNT_BAD;
            end else begin
              parse_phase = (b == CH_DOLLAR) ? P_LEN_LINE : P_LEN_BAD;
            end
          end else begin
            blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
            if (num_stopped || (!num_started && blank)) begin
              // leading blanks or text after the number: no effect
            end else if (!num_started && (b == CH_PLUS || b == CH_MINUS)) begin
              num_started = 1'b1;
              num_neg     = (b == CH_MINUS);
            end else begin
              num_started = 1'b1;
              if (b >= CH_ZERO && b <= CH_NINE) begin
                v         = num_value * 10 + (b - CH_ZERO);
                num_value = (v > NUM_SAT) ? NUM_SAT : v;
              end else begin
                num_stopped = 1'b1;
              end
            end
          end
          prev_cr = (b == CH_CR);
          line_pos++;
          if (line_pos >= LINE_MAX - 1) flag_error(ERR_LINE_LONG);
        end
      end
    endcase
  endfunction

  // request channel: one byte per transaction, random idle cycles before it
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid   = 1'b1;
    req_if.in_byte = b;
    do @(posedge clk); while (!req_if.ready);
    bytes_accepted++;
    parse_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string body);
    send_text(body);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  function automatic string char_run(input byte c, input int unsigned n);
    string s;
    s = "";
    repeat (n) s = {s, $sformatf("%c", c)};
    return s;
  endfunction

  // stop sending and let every outstanding transaction come out
  task automatic wait_idle();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_parse_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // apb transfer: setup cycle, access cycle, then the bus goes quiet
  task automatic apb_access(input logic idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_readback(input logic idx, input logic [31:0] want);
    logic [31:0] got;
    apb_access(idx, 1'b0, 32'd0, got);
    if (got !== want) begin
      fail_count++;
      $display("[%0t] register %0d readback, expected %0h, actual %0h", $time, idx,
               want, got);
    end
  endtask

  // limits only change while the parser is idle
  task automatic program_limit(input logic idx, input int unsigned value);
    logic [31:0] unused;
    wait_idle();
    apb_access(idx, 1'b1, value, unused);
    if (idx == REG_LENGTH_LIMIT) length_lim = value & 32'h7FF;
    else count_lim = value & 32'hFFFF;
    check_readback(idx, (idx == REG_LENGTH_LIMIT) ? length_lim : count_lim);
  endtask

  task automatic send_good_request(input int unsigned n_args, input int unsigned max_len);
    int unsigned len;
    send_line($sformatf("*%0d", n_args));
    repeat (n_args) begin
      len = $urandom_range(max_len);
      send_line($sformatf("$%0d", len));
      repeat (len) send_byte(8'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
      end else begin
        send_line("");
      end
    end
  endtask

  // response channel: random stalls, then compare against the oldest expectation
  always @(negedge clk) begin
    rsp_if.ready = !rst && ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("[%0t] %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    rcap_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_parse_results.size() == 0) begin
        fail_count++;
        $display("[%0t] unexpected transaction, expected none, actual kind %0d", $time,
                 rsp_if.kind);
      end else begin
        want = pending_parse_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(rsp_if.kind));
        check_field("data_byte", 16'(want.data_byte), 16'(rsp_if.data_byte));
        check_field("arg_index", want.arg_index, rsp_if.arg_index);
        check_field("arg_length", 16'(want.arg_length), 16'(rsp_if.arg_length));
        check_field("last_arg", 16'(want.last_arg), 16'(rsp_if.last_arg));
        check_field("arg_count", want.arg_count, rsp_if.arg_count);
        check_field("error_code", 16'(want.error_code), 16'(rsp_if.error_code));
      end
    end
  end

  // watchdog over the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // reset values, then each register written and read back
  task automatic test_register_access();
    check_readback(REG_LENGTH_LIMIT, 32'(LENGTH_LIMIT_RST));
    check_readback(REG_COUNT_LIMIT, 32'(COUNT_LIMIT_RST));
    program_limit(REG_LENGTH_LIMIT, 700);
    program_limit(REG_COUNT_LIMIT, 12345);
    program_limit(REG_LENGTH_LIMIT, 100);
    program_limit(REG_COUNT_LIMIT, 64);
  endtask

  // complete requests, empty requests and the atoi-style number forms
  task automatic test_well_formed();
    // two arguments, the second of zero length
    send_line("*2");
    send_line("$3");
    send_text("abc");
    send_line("");
    send_line("$0");
    send_line("");
    // payload byte extremes, line characters inside payload, odd trailer
    send_line("*1");
    send_line("$4");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("XY");
    // zero, negative, missing and non-numeric counts all end empty
    send_line("*0");
    send_line("*-5");
    send_line("*");
    send_line("*abc");
    send_line("*-0");
    // blanks, sign, text after the digits; minus zero is a zero length
    send_line($sformatf("* %c+2x9", CH_TAB));
    send_line("$-0");
    send_line("");
    send_line("$+1z5");
    send_text("Q");
    send_line("");
    // a cr without lf ends the digits but not the line
    send_line($sformatf("*1%cQ", CH_CR));
    send_line("$1");
    send_text("k");
    send_line("");
    wait_idle();
  endtask

  task automatic test_errors();
    // wrong markers on the count line and on length lines
    send_line("+3");
    send_line("$1");
    send_line("*2");
    send_line("*1");
    send_line("*2");
    send_line("$1");
    send_text("a");
    send_line("");
    send_line("x1");
    // bad lengths: negative, at the limit, saturated
    send_line("*1");
    send_line("$-1");
    send_line("*1");
    send_line("$100");
    send_line("*1");
    send_line("$131072");
    // counts over the limit, one plain and one saturated
    send_line("*65");
    send_line("*99999999");
    wait_idle();
  endtask

  // header lines around the length boundary
  task automatic test_line_length();
    // longest line that still fits
    send_line({"*", char_run("0", LINE_MAX - 5), "1"});
    send_line("$0");
    send_line("");
    // one byte more: the cr overflows, the lf opens a new request
    send_line({"*", char_run("5", LINE_MAX - 3)});
    send_line("");
    // overflow on a length line
    send_line("*1");
    send_text({"$", char_run(" ", LINE_MAX - 2)});
    send_line("*0");
    wait_idle();
  endtask

  task automatic test_limit_extremes();
    program_limit(REG_LENGTH_LIMIT, 1);
    send_line("*1");
    send_line("$0");
    send_line("");
    send_line("*1");
    send_line("$1");
    program_limit(REG_LENGTH_LIMIT, 1024);
    send_good_request(1, 0);
    send_line("*1");
    send_line("$1023");
    repeat (1023) send_byte(8'($urandom_range(255)));
    send_line("");
    send_line("*1");
    send_line("$1024");
    program_limit(REG_COUNT_LIMIT, 1);
    send_good_request(1, 3);
    send_line("*2");
    program_limit(REG_COUNT_LIMIT, 65535);
    // largest count accepted, then cut short by a bad marker
    send_line("*65535");
    send_line("$1");
    send_text("a");
    send_line("");
    send_line("!2");
    send_line("*65536");
    program_limit(REG_LENGTH_LIMIT, 100);
    program_limit(REG_COUNT_LIMIT, 64);
  endtask

  // mostly well-formed requests with random content, the rest broken ones
  task automatic run_random_phase(input int unsigned budget);
    int unsigned start_count;
    int unsigned pick;
    int unsigned len_cap;
    int unsigned small_len;
    int unsigned big_len;
    int unsigned max_args;
    logic [7:0]  marker;
    start_count = bytes_accepted;
    len_cap     = (length_lim > LEN_CAP) ? LEN_CAP : length_lim;
    small_len   = (len_cap - 1 < 10) ? len_cap - 1 : 10;
    big_len     = (len_cap - 1 < 200) ? len_cap - 1 : 200;
    max_args    = (count_lim < 4) ? count_lim : 4;
    while (bytes_accepted - start_count < budget) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_good_request($urandom_range(max_args, 1),
                          ($urandom_range(19) == 0) ? big_len : small_len);
      end else if (pick < 74) begin
        case ($urandom_range(3))
          0: send_line("*0");
          1: send_line($sformatf("*-%0d", $urandom_range(99)));
          2: send_line("*");
          default: send_line("*x2");
        endcase
      end else if (pick < 79) begin
        marker = 8'($urandom_range(255));
        if (marker == CH_STAR) marker = CH_DOLLAR;
        send_byte(marker);
        send_line("3");
      end else if (pick < 84) begin
        send_line($sformatf("*%0d", count_lim + 1 + $urandom_range(3)));
      end else if (pick < 89) begin
        send_line($sformatf("*%0d", $urandom_range(max_args, 1)));
        case ($urandom_range(2))
          0: send_line("#2");
          1: send_line($sformatf("$-%0d", $urandom_range(9, 1)));
          default: send_line($sformatf("$%0d", len_cap + $urandom_range(5)));
        endcase
      end else if (pick < 94) begin
        // request cut off inside the payload, the next one is swallowed
        send_line("*2");
        send_line("$5");
        repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)));
      end else if (pick < 98) begin
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
      end else begin
        send_text({"*", char_run("9", LINE_MAX - 2)});
      end
      // sender holds off now and then until the parser has drained
      if ($urandom_range(39) == 0) wait_idle();
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;
    stall_pct     = 0;
    program_limit(REG_LENGTH_LIMIT, 100);
    program_limit(REG_COUNT_LIMIT, 64);
    run_random_phase(160);
    send_idle_pct = 88;
    stall_pct     = 0;
    program_limit(REG_LENGTH_LIMIT, 1);
    program_limit(REG_COUNT_LIMIT, 1);
    run_random_phase(160);
    send_idle_pct = 0;
    stall_pct     = 88;
    program_limit(REG_LENGTH_LIMIT, 1024);
    program_limit(REG_COUNT_LIMIT, 65535);
    run_random_phase(160);
    send_idle_pct = 9;
    stall_pct     = 9;
    program_limit(REG_LENGTH_LIMIT, $urandom_range(60, 2));
    program_limit(REG_COUNT_LIMIT, $urandom_range(8, 1));
    run_random_phase(160);
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_if.valid   = 1'b0;
    req_if.in_byte = 8'h00;
    fail_count     = 0;
    bytes_accepted = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    length_lim     = 32'(LENGTH_LIMIT_RST);
    count_lim      = 32'(COUNT_LIMIT_RST);
    restart_request();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_access();
    test_well_formed();
    test_errors();
    test_line_length();
    test_limit_extremes();
    test_random_traffic();
    wait_idle();

    if (fail_count == 0 && pending_parse_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
